// File: design/bwr_pkg.sv
// Shared types, constants and color classing for the bitplane framebuffer.
`timescale 1ns / 1ps

package bwr_pkg;

    // Panel geometry
    localparam int VISIBLE_WIDTH = 122;
    localparam int LINE_PITCH    = 128;
    localparam int ROW_COUNT     = 250;
    localparam int PLANE_BYTES   = (LINE_PITCH * ROW_COUNT) / 8;

    // Byte address width of one plane
    localparam int ADDR_W = (PLANE_BYTES > 1) ? $clog2(PLANE_BYTES) : 1;

    // x (8b) + y (9b) * pitch (up to 256) fits in 17 bits, SUM_W keeps 18; byte position drops 3
    localparam int SUM_W = 9 + 8 + 1;
    localparam int POS_W = SUM_W - 3;

    // Opcodes
    localparam logic [1:0] OP_DRAW = 2'd0;
    localparam logic [1:0] OP_FILL = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [7:0] LEVEL_FULL = 8'hff;
    localparam logic [7:0] MSB_MASK   = 8'h80;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  x;
        logic [8:0]  y;
        logic [7:0]  red_level;
        logic [7:0]  green_level;
        logic [7:0]  blue_level;
        logic [7:0]  white_level;
        logic        plane_select;
        logic [11:0] byte_index;
    } in_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       out_of_bounds;
    } out_t;

    // Plane bits for a color: black -> (0,0), red -> (1,1), anything else -> (1,0)
    typedef struct packed {
        logic mono;
        logic red;
    } plane_bits_t;

    function automatic plane_bits_t classify(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b, input logic [7:0] w);
        plane_bits_t bits;
        logic        is_black;
        logic        is_red;
        is_black  = (r == LEVEL_FULL) && (g == LEVEL_FULL) &&
                    (b == LEVEL_FULL) && (w == LEVEL_FULL);
        is_red    = (r != 8'd0) && (g == 8'd0) && (b == 8'd0);
        bits.mono = !is_black;
        bits.red  = is_red;
        return bits;
    endfunction

endpackage

// File: design/bwr_bitplane_framebuffer.sv
// Two-plane 1-bit framebuffer (black/white plane and red plane) with draw, fill and read.
`timescale 1ns / 1ps

// Holds a black/white plane and a red plane of PLANE_BYTES bytes each
// (4000 with a 128-pixel line pitch and 250 rows), pixels packed MSB first.
// One transfer in gives exactly one transfer out. Steps, from the
// accepting edge to the result on m_valid:
//   draw  - byte read, bit merge and write back, result
//   read  - byte read, capture, result
//   out-of-bounds draw, read past the plane end, unused opcode - result only
//   fill  - every byte of both planes, one byte of each plane written a cycle, then result
// Everything runs through the single address/data port of each plane
// memory, so items are handled one at a time: s_ready is high only while
// the sequencer is idle. A finished result sits in the output register and
// does not hold off the next transfer in; the next result waits for it.
// After reset both planes are swept to zero, one byte per cycle, over all
// PLANE_BYTES (4000) addresses; s_ready stays low during the sweep.
module bwr_bitplane_framebuffer (
    input  logic          aclk,
    input  logic          aresetn,

    input  logic          s_valid,
    output logic          s_ready,
    input  bwr_pkg::in_t  s_data,

    output logic          m_valid,
    input  logic          m_ready,
    output bwr_pkg::out_t m_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEM_RD,
        ST_DRAW_WR,
        ST_READ_CAP,
        ST_FILL,
        ST_DONE
    } state_t;

    localparam logic [bwr_pkg::ADDR_W-1:0] LAST_ADDR =
        bwr_pkg::ADDR_W'(bwr_pkg::PLANE_BYTES - 1);

    // Plane storage, no reset: cleared by the sweep after reset
    logic [7:0] mono_mem [bwr_pkg::PLANE_BYTES];
    logic [7:0] red_mem  [bwr_pkg::PLANE_BYTES];

    state_t                    state_reg, state_next;
    logic [bwr_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic                      is_draw_reg, is_draw_next;
    logic                      plane_reg, plane_next;
    logic [7:0]                mask_reg, mask_next;
    logic                      mono_bit_reg, mono_bit_next;
    logic                      red_bit_reg, red_bit_next;
    logic                      emit_reg, emit_next;
    logic                      m_valid_reg, m_valid_next;
    bwr_pkg::out_t             m_data_reg, m_data_next;
    bwr_pkg::out_t             res_reg, res_next;

    logic [7:0]                mono_rd_reg;
    logic [7:0]                red_rd_reg;

    logic                      mem_we;
    logic [7:0]                mono_wdata;
    logic [7:0]                red_wdata;

    // Decode of the incoming transfer
    bwr_pkg::plane_bits_t      color;
    logic [bwr_pkg::SUM_W-1:0] bit_pos;
    logic [bwr_pkg::POS_W-1:0] byte_pos;
    logic                      draw_ok;
    logic                      read_ok;
    logic                      accept;
    logic                      slot_free;

    assign accept    = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        color    = bwr_pkg::classify(s_data.red_level, s_data.green_level,
                                     s_data.blue_level, s_data.white_level);
        bit_pos  = bwr_pkg::SUM_W'(s_data.x) +
                   bwr_pkg::SUM_W'(s_data.y) * bwr_pkg::SUM_W'(bwr_pkg::LINE_PITCH);
        byte_pos = bit_pos[bwr_pkg::SUM_W-1:3];
        draw_ok  = ({1'b0, s_data.x} < 9'(bwr_pkg::VISIBLE_WIDTH)) &&
                   ({1'b0, s_data.y} < 10'(bwr_pkg::ROW_COUNT)) &&
                   (byte_pos < bwr_pkg::POS_W'(bwr_pkg::PLANE_BYTES));
        read_ok  = bwr_pkg::POS_W'(s_data.byte_index) < bwr_pkg::POS_W'(bwr_pkg::PLANE_BYTES);
    end

    // Write port: fill bytes during a sweep, merged byte on a draw write-back
    always_comb begin
        mem_we = 1'b0;
        if (state_reg == ST_FILL) begin
            mem_we     = 1'b1;
            mono_wdata = {8{mono_bit_reg}};
            red_wdata  = {8{red_bit_reg}};
        end else begin
            mem_we     = (state_reg == ST_DRAW_WR);
            mono_wdata = (mono_rd_reg & ~mask_reg) | (mono_bit_reg ? mask_reg : 8'h00);
            red_wdata  = (red_rd_reg & ~mask_reg) | (red_bit_reg ? mask_reg : 8'h00);
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mono_mem[addr_reg] <= mono_wdata;
            red_mem[addr_reg]  <= red_wdata;
        end
        mono_rd_reg <= mono_mem[addr_reg];
        red_rd_reg  <= red_mem[addr_reg];
    end

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        is_draw_next  = is_draw_reg;
        plane_next    = plane_reg;
        mask_next     = mask_reg;
        mono_bit_next = mono_bit_reg;
        red_bit_next  = red_bit_reg;
        emit_next     = emit_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_next      = '0;
                    mono_bit_next = color.mono;
                    red_bit_next  = color.red;
                    plane_next    = s_data.plane_select;
                    mask_next     = bwr_pkg::MSB_MASK >> s_data.x[2:0];
                    unique case (s_data.opcode)
                        bwr_pkg::OP_DRAW: begin
                            is_draw_next = 1'b1;
                            addr_next    = byte_pos[bwr_pkg::ADDR_W-1:0];
                            if (draw_ok) begin
                                state_next = ST_MEM_RD;
                            end else begin
                                res_next.out_of_bounds = 1'b1;
                                state_next             = ST_DONE;
                            end
                        end
                        bwr_pkg::OP_FILL: begin
                            addr_next  = '0;
                            emit_next  = 1'b1;
                            state_next = ST_FILL;
                        end
                        bwr_pkg::OP_READ: begin
                            is_draw_next = 1'b0;
                            addr_next    = s_data.byte_index[bwr_pkg::ADDR_W-1:0];
                            state_next   = read_ok ? ST_MEM_RD : ST_DONE;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_MEM_RD: begin
                // address is on the port; data lands in the read registers
                state_next = is_draw_reg ? ST_DRAW_WR : ST_READ_CAP;
            end
            ST_DRAW_WR: begin
                state_next = ST_DONE;
            end
            ST_READ_CAP: begin
                res_next.read_byte = plane_reg ? red_rd_reg : mono_rd_reg;
                state_next         = ST_DONE;
            end
            ST_FILL: begin
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST_ADDR) begin
                    addr_next  = '0;
                    state_next = emit_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // start with the zero-clearing sweep, which gives no result
            state_reg    <= ST_FILL;
            addr_reg     <= '0;
            mono_bit_reg <= 1'b0;
            red_bit_reg  <= 1'b0;
            emit_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
            is_draw_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            mono_bit_reg <= mono_bit_next;
            red_bit_reg  <= red_bit_next;
            emit_reg     <= emit_next;
            m_valid_reg  <= m_valid_next;
            is_draw_reg  <= is_draw_next;
        end
        plane_reg  <= plane_next;
        mask_reg   <= mask_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
